FILE: design/hgcp_pkg.sv
// Package for the hex gamepad command parser: phase types, result record,
// character codes and the hex digit decoder. No dependencies.
`default_nettype none

package hgcp_pkg;

    localparam int CHAR_W      = 8;
    localparam int FLAGS_W     = 16;
    localparam int BUTTONS_W   = 14;
    localparam int TOKEN_CNT_W = 3;
    localparam int RESULT_W    = 1 + BUTTONS_W + 5 * CHAR_W;
    localparam int TDATA_OUT_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [TOKEN_CNT_W-1:0] TOKENS_USED = 3'd6;
    localparam logic [TOKEN_CNT_W-1:0] FIRST_STICK = 3'd2;
    localparam logic [TOKEN_CNT_W-1:0] LAST_STICK  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'd70;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'd88;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'd102;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'd120;

    localparam logic [BUTTONS_W-1:0] BUTTONS_RESET = '0;
    localparam logic [CHAR_W-1:0]    HAT_RESET     = 8'd8;
    localparam logic [CHAR_W-1:0]    AXIS_RESET    = 8'd128;

    typedef enum logic [1:0] {
        LP_AWAIT,
        LP_ACTIVE,
        LP_REJECT
    } t_line_phase;

    typedef enum logic [1:0] {
        TP_BETWEEN,
        TP_LEADZERO,
        TP_DIGITS
    } t_tok_phase;

    typedef struct packed {
        logic                 accepted;
        logic [BUTTONS_W-1:0] button_bits;
        logic [CHAR_W-1:0]    hat_value;
        logic [CHAR_W-1:0]    left_x;
        logic [CHAR_W-1:0]    left_y;
        logic [CHAR_W-1:0]    right_x;
        logic [CHAR_W-1:0]    right_y;
    } t_result;

    function automatic logic is_line_end(input logic [CHAR_W-1:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
    endfunction

    // Returns {valid, value} for a hex digit character.
    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            d = c - CH_UP_A + 8'd10;
            return {1'b1, d[3:0]};
        end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            d = c - CH_LO_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

FILE: design/hgcp_in_stage.sv
// Input register of the hex gamepad command parser.
// Holds one received character until the parser takes it. Uses hgcp_pkg.
`default_nettype none

module hgcp_in_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [hgcp_pkg::CHAR_W-1:0] i_char,
    input  wire logic                        i_take,
    output logic                             o_valid,
    output logic [hgcp_pkg::CHAR_W-1:0]      o_char
);
    import hgcp_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_char  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

endmodule

`default_nettype wire

FILE: design/hgcp_parser.sv
// Line parser of the hex gamepad command parser: token state, pending
// fields and the stored gamepad state. Uses hgcp_pkg.
`default_nettype none

module hgcp_parser (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [hgcp_pkg::CHAR_W-1:0] i_char,
    output hgcp_pkg::t_result                o_result
);
    import hgcp_pkg::*;

    t_line_phase            r_phase, n_phase;
    t_tok_phase             r_tok, n_tok;
    logic [TOKEN_CNT_W-1:0] r_tn, n_tn;
    logic                   r_invalid, n_invalid;
    logic [FLAGS_W-1:0]     r_acc, n_acc;
    logic [FLAGS_W-1:0]     r_flags, n_flags;
    logic [CHAR_W-1:0]      r_phat, n_phat;
    logic [CHAR_W-1:0]      r_sticks [4];
    logic [CHAR_W-1:0]      n_sticks [4];
    logic [3:0]             r_present, n_present;
    logic [BUTTONS_W-1:0]   r_buttons, n_buttons;
    logic [CHAR_W-1:0]      r_hat, n_hat;
    logic [CHAR_W-1:0]      r_axes [4];
    logic [CHAR_W-1:0]      n_axes [4];

    logic                   is_end, is_blank, is_dec, is_zero, is_x, hex_ok;
    logic [3:0]             hex_d;
    logic [4:0]             hex_dec;
    logic [1:0]             tk_idx;
    logic                   run, digit, do_commit, do_shift, do_fill, line_ok;
    logic [FLAGS_W-1:0]     p_flags;
    logic [CHAR_W-1:0]      p_hat;
    logic [CHAR_W-1:0]      p_sticks [4];
    logic [3:0]             p_present;
    logic [TOKEN_CNT_W-1:0] p_tn;
    logic [CHAR_W-1:0]      v [4];

    assign is_end   = is_line_end(i_char);
    assign is_blank = (i_char == CH_SPACE) || (i_char == CH_TAB);
    assign is_dec   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_zero  = (i_char == CH_ZERO);
    assign is_x     = (i_char == CH_LO_X) || (i_char == CH_UP_X);
    assign hex_dec  = hex_decode(i_char);
    assign hex_ok   = hex_dec[4];
    assign hex_d    = hex_dec[3:0];
    assign tk_idx   = 2'(r_tn - FIRST_STICK);

    always_comb begin
        run       = 1'b0;
        digit     = 1'b0;
        do_commit = 1'b0;
        do_shift  = 1'b0;
        do_fill   = 1'b0;
        n_phase   = r_phase;
        n_tok     = r_tok;
        n_acc     = r_acc;

        if (i_step) begin
            if (is_end) begin
                do_commit = (r_phase == LP_ACTIVE) && !r_invalid && (r_tok != TP_BETWEEN);
            end else begin
                unique case (r_phase)
                    LP_AWAIT: begin
                        if (!is_blank) begin
                            if (is_dec) begin
                                n_phase = LP_ACTIVE;
                                run     = 1'b1;
                            end else begin
                                n_phase = LP_REJECT;
                            end
                        end
                    end
                    LP_ACTIVE: begin
                        run = !r_invalid;
                    end
                    default: begin
                        run = 1'b0;
                    end
                endcase
                if (run) begin
                    case (r_tok)
                        TP_BETWEEN: begin
                            if (!is_blank) begin
                                if (is_zero) begin
                                    n_tok = TP_LEADZERO;
                                end else begin
                                    n_tok = TP_DIGITS;
                                    digit = 1'b1;
                                end
                            end
                        end
                        TP_LEADZERO: begin
                            n_tok = TP_DIGITS;
                            digit = !is_x;
                        end
                        default: begin
                            digit = 1'b1;
                        end
                    endcase
                end
                if (digit) begin
                    if (is_blank) begin
                        do_commit = 1'b1;
                    end else if (hex_ok) begin
                        do_shift = 1'b1;
                    end else begin
                        do_commit = 1'b1;
                        do_fill   = 1'b1;
                    end
                end
            end
        end

        p_flags   = r_flags;
        p_hat     = r_phat;
        p_sticks  = r_sticks;
        p_present = r_present;
        p_tn      = r_tn;
        if (do_commit) begin
            if (r_tn == '0) begin
                p_flags = r_acc;
            end else if (r_tn == 3'd1) begin
                p_hat = r_acc[CHAR_W-1:0];
            end else if ((r_tn >= FIRST_STICK) && (r_tn <= LAST_STICK)) begin
                p_sticks[tk_idx]  = r_acc[CHAR_W-1:0];
                p_present[tk_idx] = 1'b1;
            end
            if (r_tn < TOKENS_USED) begin
                p_tn = r_tn + 3'd1;
            end
            n_acc = '0;
            n_tok = TP_BETWEEN;
        end
        if (do_shift) begin
            n_acc = {r_acc[FLAGS_W-5:0], hex_d};
        end
        if (do_fill) begin
            for (int i = 0; i < 4; i++) begin
                if ((3'(i) + FIRST_STICK) >= p_tn) begin
                    p_sticks[i]  = '0;
                    p_present[i] = 1'b1;
                end
            end
        end

        for (int i = 0; i < 4; i++) begin
            v[i] = p_present[i] ? p_sticks[i] : r_axes[i];
        end
        line_ok   = i_step && is_end && (r_phase == LP_ACTIVE);
        n_axes    = r_axes;
        n_hat     = r_hat;
        n_buttons = r_buttons;
        if (line_ok) begin
            n_hat = p_hat;
            if (p_flags[1]) begin
                n_axes[0] = v[0];
                n_axes[1] = v[1];
            end
            if (p_flags[0]) begin
                n_axes[2] = p_flags[1] ? v[2] : v[0];
                n_axes[3] = p_flags[1] ? v[3] : v[1];
            end
            n_buttons = p_flags[FLAGS_W-1:2];
        end

        if (i_step && is_end) begin
            n_phase   = LP_AWAIT;
            n_tok     = TP_BETWEEN;
            n_tn      = '0;
            n_invalid = 1'b0;
            n_acc     = '0;
            n_flags   = '0;
            n_phat    = '0;
            n_present = '0;
            for (int i = 0; i < 4; i++) begin
                n_sticks[i] = '0;
            end
        end else begin
            n_tn      = p_tn;
            n_invalid = r_invalid || do_fill;
            n_flags   = p_flags;
            n_phat    = p_hat;
            n_present = p_present;
            n_sticks  = p_sticks;
        end

        o_result.accepted    = line_ok;
        o_result.button_bits = n_buttons;
        o_result.hat_value   = n_hat;
        o_result.left_x      = n_axes[0];
        o_result.left_y      = n_axes[1];
        o_result.right_x     = n_axes[2];
        o_result.right_y     = n_axes[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= LP_AWAIT;
            r_tok     <= TP_BETWEEN;
            r_tn      <= '0;
            r_invalid <= 1'b0;
            r_acc     <= '0;
            r_flags   <= '0;
            r_phat    <= '0;
            r_present <= '0;
            r_buttons <= BUTTONS_RESET;
            r_hat     <= HAT_RESET;
            for (int i = 0; i < 4; i++) begin
                r_sticks[i] <= '0;
                r_axes[i]   <= AXIS_RESET;
            end
        end else begin
            r_phase   <= n_phase;
            r_tok     <= n_tok;
            r_tn      <= n_tn;
            r_invalid <= n_invalid;
            r_acc     <= n_acc;
            r_flags   <= n_flags;
            r_phat    <= n_phat;
            r_present <= n_present;
            r_buttons <= n_buttons;
            r_hat     <= n_hat;
            r_sticks  <= n_sticks;
            r_axes    <= n_axes;
        end
    end

endmodule

`default_nettype wire

FILE: design/hgcp_out_stage.sv
// Result register of the hex gamepad command parser.
// Holds one line result until the downstream side takes it. Uses hgcp_pkg.
`default_nettype none

module hgcp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire hgcp_pkg::t_result i_result,
    input  wire logic              i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output hgcp_pkg::t_result      o_result
);
    import hgcp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: design/hex_gamepad_command_parser_top.sv
// Top level of the hex gamepad command parser.
// Instantiates hgcp_in_stage, hgcp_parser and hgcp_out_stage; uses hgcp_pkg.
//
//   Channel    Direction  Payload (low bit first)
//   s_axis     in         tdata[7:0] char_byte
//   m_axis     out        tdata[0] accepted, [14:1] button_bits, [22:15] hat_value,
//                         [30:23] left_x, [38:31] left_y, [46:39] right_x,
//                         [54:47] right_y, [55] zero
//
// A character is taken every cycle while no line end is held back; its state update and
// its line result for a CR, LF or NUL are registered as it leaves the input register.
// The parser step is a single pass of logic between the input and result registers.
// A line end waits in the input register while the result register is still full;
// other characters keep flowing during an output stall.
// Reset is synchronous, active low, and restores hat 8, sticks 128, buttons 0.
`default_nettype none

module hex_gamepad_command_parser_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // char_byte
    input  wire logic [hgcp_pkg::CHAR_W-1:0]       i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // accepted, button_bits, hat_value, left_x, left_y, right_x, right_y, zero pad
    output logic [hgcp_pkg::TDATA_OUT_W-1:0]       o_m_axis_tdata
);
    import hgcp_pkg::*;

    logic              in_valid;
    logic [CHAR_W-1:0] in_char;
    logic              out_free;
    logic              step;
    logic              load;
    t_result           step_result;
    t_result           out_result;

    assign step = in_valid && (!is_line_end(in_char) || out_free);
    assign load = step && is_line_end(in_char);

    hgcp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_char  (i_s_axis_tdata),
        .i_take  (step),
        .o_valid (in_valid),
        .o_char  (in_char)
    );

    hgcp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (in_char),
        .o_result (step_result)
    );

    hgcp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (step_result),
        .i_ready  (i_m_axis_tready),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {
        (TDATA_OUT_W - RESULT_W)'(0),
        out_result.right_y,
        out_result.right_x,
        out_result.left_y,
        out_result.left_x,
        out_result.hat_value,
        out_result.button_bits,
        out_result.accepted
    };

endmodule

`default_nettype wire

FILE: design/hgcp_checker.sv
// Port-level checker for the hex gamepad command parser, bound to the top level.
// Uses hgcp_pkg for field widths and reset values.
`default_nettype none

module hgcp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [hgcp_pkg::TDATA_OUT_W-1:0]  o_m_axis_tdata
);
    import hgcp_pkg::*;

    // Stored fields as last reported, starting from the reset values.
    logic [RESULT_W-2:0] r_prev;
    logic                out_fire;

    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= {AXIS_RESET, AXIS_RESET, AXIS_RESET, AXIS_RESET, HAT_RESET,
                       BUTTONS_RESET};
        end else if (out_fire) begin
            r_prev <= o_m_axis_tdata[RESULT_W-1:1];
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result transaction offered right after reset.");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("Result transaction withdrawn while stalled.");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("Result transaction changed while stalled.");

    a_reject_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[RESULT_W-1:1] == r_prev)
        else $error("Rejected line changed the stored gamepad state.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[TDATA_OUT_W-1:RESULT_W] == '0)
        else $error("Padding bits of a result transaction are not zero.");

endmodule

bind hex_gamepad_command_parser_top hgcp_checker u_hgcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for hex_gamepad_command_parser_top: streams characters,
// predicts each line result in a scoreboard class, and checks every result transaction.
// Depends on hgcp_pkg and the design files under design/.
`timescale 1ns / 1ps

import hgcp_pkg::*;

class gamepad_scoreboard;
    t_line_phase       line_st;
    t_tok_phase        tok_st;
    int                tok_idx;
    bit                skip_rest;
    logic [15:0]       acc;
    logic [15:0]       flags_in;
    logic [7:0]        hat_in;
    logic [7:0]        stick_in [4];
    logic [3:0]        stick_given;
    logic [13:0]       buttons;
    logic [7:0]        hat;
    logic [7:0]        axes [4];
    t_result           line_results [$];
    int                errors;
    int                chars_seen;
    int                lines_applied;
    int                lines_rejected;

    function new();
        buttons = BUTTONS_RESET;
        hat = HAT_RESET;
        foreach (axes[i]) axes[i] = AXIS_RESET;
        errors = 0;
        chars_seen = 0;
        lines_applied = 0;
        lines_rejected = 0;
        clear_line();
    endfunction

    function void clear_line();
        line_st = LP_AWAIT;
        tok_st = TP_BETWEEN;
        tok_idx = 0;
        skip_rest = 1'b0;
        acc = '0;
        flags_in = '0;
        hat_in = '0;
        foreach (stick_in[i]) stick_in[i] = '0;
        stick_given = '0;
    endfunction

    function int hex_nibble(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_UP_A && c <= CH_UP_F) return c - CH_UP_A + 10;
        if (c >= CH_LO_A && c <= CH_LO_F) return c - CH_LO_A + 10;
        return -1;
    endfunction

    function void close_token();
        if (tok_idx == 0) begin
            flags_in = acc;
        end else if (tok_idx == 1) begin
            hat_in = acc[7:0];
        end else if (tok_idx < TOKENS_USED) begin
            stick_in[tok_idx - FIRST_STICK] = acc[7:0];
            stick_given[tok_idx - FIRST_STICK] = 1'b1;
        end
        if (tok_idx < TOKENS_USED) tok_idx++;
        acc = '0;
        tok_st = TP_BETWEEN;
    endfunction

    function void digit_step(logic [7:0] c);
        int d;
        d = hex_nibble(c);
        if (c == CH_SPACE || c == CH_TAB) begin
            close_token();
        end else if (d >= 0) begin
            acc = (acc << 4) | 16'(d);
        end else begin
            close_token();
            for (int k = tok_idx; k < TOKENS_USED; k++) begin
                if (k >= FIRST_STICK) begin
                    stick_in[k - FIRST_STICK] = '0;
                    stick_given[k - FIRST_STICK] = 1'b1;
                end
            end
            skip_rest = 1'b1;
        end
    endfunction

    function void token_step(logic [7:0] c);
        if (skip_rest) return;
        case (tok_st)
            TP_BETWEEN: begin
                if (c == CH_SPACE || c == CH_TAB) return;
                acc = '0;
                if (c == CH_ZERO) begin
                    tok_st = TP_LEADZERO;
                end else begin
                    tok_st = TP_DIGITS;
                    digit_step(c);
                end
            end
            TP_LEADZERO: begin
                tok_st = TP_DIGITS;
                if (c != CH_LO_X && c != CH_UP_X) digit_step(c);
            end
            default: digit_step(c);
        endcase
    endfunction

    function void apply_line();
        logic [7:0] v [4];
        for (int i = 0; i < 4; i++) v[i] = stick_given[i] ? stick_in[i] : axes[i];
        hat = hat_in;
        if (flags_in[1]) begin
            axes[0] = v[0];
            axes[1] = v[1];
        end
        if (flags_in[0]) begin
            axes[2] = flags_in[1] ? v[2] : v[0];
            axes[3] = flags_in[1] ? v[3] : v[1];
        end
        buttons = flags_in[15:2];
    endfunction

    function void note_char(logic [7:0] c);
        t_result r;
        chars_seen++;
        if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
            r.accepted = 1'b0;
            if (line_st == LP_ACTIVE) begin
                if (!skip_rest && tok_st != TP_BETWEEN) close_token();
                apply_line();
                r.accepted = 1'b1;
            end
            if (r.accepted) lines_applied++;
            else lines_rejected++;
            r.button_bits = buttons;
            r.hat_value = hat;
            r.left_x = axes[0];
            r.left_y = axes[1];
            r.right_x = axes[2];
            r.right_y = axes[3];
            line_results.push_back(r);
            clear_line();
            return;
        end
        case (line_st)
            LP_AWAIT: begin
                if (c == CH_SPACE || c == CH_TAB) return;
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    line_st = LP_ACTIVE;
                    token_step(c);
                end else begin
                    line_st = LP_REJECT;
                end
            end
            LP_ACTIVE: token_step(c);
            default: ;
        endcase
    endfunction

    function void check_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [TDATA_OUT_W-1:0] d);
        t_result want;
        if (line_results.size() == 0) begin
            $display("%0t ns: result 0x%h with no line pending", $time, d);
            errors++;
            return;
        end
        want = line_results.pop_front();
        check_field("accepted", want.accepted, d[0]);
        check_field("button_bits", want.button_bits, d[14:1]);
        check_field("hat_value", want.hat_value, d[22:15]);
        check_field("left_x", want.left_x, d[30:23]);
        check_field("left_y", want.left_y, d[38:31]);
        check_field("right_x", want.right_x, d[46:39]);
        check_field("right_y", want.right_y, d[54:47]);
        check_field("pad bit", 0, d[55]);
    endfunction
endclass

module testbench;
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [CHAR_W-1:0]      i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;

    gamepad_scoreboard sb;
    int                results_seen = 0;
    bit                sender_steady = 1'b0;
    string             hex_digits = "0123456789abcdefABCDEF";

    hex_gamepad_command_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic send_char(input logic [7:0] c);
        while (!sender_steady && $urandom_range(99) < 10) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= c;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_char(c);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] any_blank();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] any_line_end();
        case ($urandom_range(2))
            0: return CH_CR;
            1: return CH_LF;
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        if ($urandom_range(3) == 0) return $urandom_range(1) ? CH_LO_X : CH_UP_X;
        do c = 8'($urandom_range(255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL ||
               (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
               (c >= CH_LO_A && c <= CH_LO_F));
        return c;
    endfunction

    task automatic send_random_line();
        int  tokens;
        int  digits;
        bit  prefixed;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(6)) send_char(8'($urandom_range(255)));
            send_char(any_line_end());
            return;
        end
        if ($urandom_range(3) == 0) send_char(any_blank());
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            if (t > 0) repeat ($urandom_range(1, 2)) send_char(any_blank());
            prefixed = ($urandom_range(3) == 0);
            if (prefixed) begin
                send_char(CH_ZERO);
                send_char($urandom_range(1) ? CH_LO_X : CH_UP_X);
            end
            digits = $urandom_range(prefixed ? 0 : 1, 5);
            for (int i = 0; i < digits; i++) begin
                if (t == 0 && !prefixed && i == 0) send_char(hex_digits[$urandom_range(9)]);
                else send_char(hex_digits[$urandom_range(21)]);
            end
            if ($urandom_range(24) == 0) send_char(junk_char());
        end
        if ($urandom_range(4) == 0) send_char(any_blank());
        send_char(any_line_end());
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
            results_seen++;
        end
    end

    initial begin : sink
        bit held_off;
        held_off = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && results_seen >= 15) begin
                held_off = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            if (results_seen >= 30 && results_seen < 50) i_m_axis_tready <= 1'b1;
            else i_m_axis_tready <= ($urandom_range(99) >= 10);
        end
    end

    initial begin
        #400000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        bit drained;
        drained = 1'b0;
        sb = new();
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("\r");
        send_text("z\r");
        send_text("3\t0xf 7g\n");
        send_text("0xFFFF");
        send_char(CH_NUL);
        send_text("2 8 0 FF 1 2 3\r");

        while (sb.chars_seen < 1300) begin
            sender_steady = (sb.chars_seen >= 300 && sb.chars_seen < 600);
            if (!drained && sb.chars_seen >= 900) begin
                drained = 1'b1;
                i_s_axis_tvalid <= 1'b0;
                while (sb.line_results.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            send_random_line();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.line_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d characters and %0d line results (%0d applied, %0d rejected).",
                 sb.chars_seen, results_seen, sb.lines_applied, sb.lines_rejected);
        if (sb.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

FILE: files.f
design/hgcp_pkg.sv
design/hgcp_in_stage.sv
design/hgcp_parser.sv
design/hgcp_out_stage.sv
design/hex_gamepad_command_parser_top.sv
design/hgcp_checker.sv
test/testbench.sv
